// ----- hdl/tsw_pkg.sv -----
// shared types and constants of the tcp sender window engine
`timescale 1ns / 1ps
package tsw_pkg;

  localparam int unsigned MaxPayload = 1000;
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned QAddrW     = $clog2(QueueDepth);
  localparam int unsigned QCountW    = $clog2(QueueDepth + 1);
  localparam int unsigned RunLimit   = 64;
  localparam int unsigned RunW       = $clog2(RunLimit + 1);

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_RECV = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [0:0] CFG_ISN = 1'b0;
  localparam logic [0:0] CFG_RTO = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] bytes_ready;
    logic        stream_done;
    logic        ack_present;
    logic [31:0] ack_wrapped;
    logic [15:0] peer_window;
    logic        peer_reset;
    logic [31:0] elapsed_ms;
  } tsw_in_t;

  typedef struct packed {
    logic        seg_valid;
    logic [31:0] seg_seqno;
    logic [9:0]  seg_payload_len;
    logic        seg_syn;
    logic        seg_fin;
    logic        seg_rst;
    logic        seg_retransmit;
    logic        last_of_run;
    logic [16:0] in_flight;
    logic [8-1:0] retry_count;
  } tsw_out_t;

  // queue entry: start sequence, payload length, flags
  typedef struct packed {
    logic [63:0] start_abs;
    logic [10:0] pay;
    logic        syn;
    logic        fin;
  } tsw_seg_t;

  // memory port between engine and queue store
  typedef struct packed {
    logic              we;
    logic [QAddrW-1:0] waddr;
    tsw_seg_t          wdata;
    logic [QAddrW-1:0] raddr;
  } tsw_mem_req_t;

endpackage

// ----- hdl/tcp_sender_window_retransmit_core.sv -----
// top level of the tcp sender sequence-number engine
//
// Usage: drive an item on item and raise start while busy is low; the item
// is taken at that edge. opcode push fills the peer window with segment
// descriptors, receive takes window, ack and RST, tick advances the timer.
// Each result appears on result for one cycle with result_valid high; the
// final result of an item carries last_of_run. The receiver cannot stall.
// Steps: a receive with RST, a set error, no ack or an ack beyond the sent
// data answers from idle; any other reads the queue head, then compares it,
// for each retired segment, then reads the head once more and compares
// again unless the queue is empty. A tick answers at its timer check, or on
// a retransmit reads the head entry and then sends it. A push gives status
// or RST; its descriptors come one per cycle, each held back in a register
// until the end of the run is known. busy drops as the last result appears.
// Configuration: cfg_we, cfg_index, cfg_data write initial_seq (0) or
// initial_rto_ms (1); write only while idle, the block does not enforce it.
// Reset (rst, synchronous): window one, queue empty, RTO 1000 ms, no
// clearing pass; queue entries are written before they are read.
`timescale 1ns / 1ps
module tcp_sender_window_retransmit_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tsw_pkg::tsw_in_t  item,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              result_valid,
  output tsw_pkg::tsw_out_t result
);
  import tsw_pkg::*;

  logic [31:0]  initial_seq, initial_rto_ms;
  tsw_mem_req_t mem_req;
  tsw_seg_t     mem_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_seq <= '0;
      initial_rto_ms <= 32'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ISN: initial_seq <= cfg_data;
        CFG_RTO: initial_rto_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  tsw_engine u_engine (
    .clk, .rst, .start, .busy, .item, .initial_seq, .initial_rto_ms,
    .mem_req, .mem_rdata, .result_valid, .result
  );

  tsw_queue_mem u_mem (.clk, .req(mem_req), .rdata(mem_rdata));

endmodule

// ----- hdl/tsw_queue_mem.sv -----
// retransmission queue store, one write and one registered read per cycle
`timescale 1ns / 1ps
module tsw_queue_mem (
  input  logic              clk,
  input  tsw_pkg::tsw_mem_req_t req,
  output tsw_pkg::tsw_seg_t rdata
);
  import tsw_pkg::*;

  tsw_seg_t mem [QueueDepth];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

// ----- hdl/tsw_engine.sv -----
// sequencer for push, receive and tick items over the queue store
`timescale 1ns / 1ps
module tsw_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tsw_pkg::tsw_in_t  item,
  input  logic [31:0]       initial_seq,
  input  logic [31:0]       initial_rto_ms,
  output tsw_pkg::tsw_mem_req_t mem_req,
  input  tsw_pkg::tsw_seg_t mem_rdata,
  output logic              result_valid,
  output tsw_pkg::tsw_out_t result
);
  import tsw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PUSH, S_RECV_RD, S_RECV_CHK, S_TICK, S_TICK_RD, S_TICK_OUT
  } state_t;

  state_t             state;
  tsw_in_t            cur;
  logic [63:0]        next_abs_seq;
  logic [16:0]        flight_count;
  logic [7:0]         retries;
  logic [15:0]        window_held;
  logic               syn_sent, fin_sent, error_flag, timer_on;
  logic [31:0]        timer_elapsed, current_rto;
  logic [QAddrW-1:0]  queue_head;
  logic [QCountW-1:0] queue_count;
  logic [15:0]        remaining;
  logic [RunW-1:0]    run_n;
  logic [63:0]        ack_abs;
  logic               retired;
  tsw_out_t           pend, pend_last;

  // push step terms
  logic [16:0] win, avail, room;
  logic        syn_b;
  logic [10:0] pay;
  logic        fin_b;
  logic [12:0] seg_len;
  logic        push_stop, push_err;

  always_comb begin
    win   = (window_held == 16'd0) ? 17'd1 : {1'b0, window_held};
    avail = win - flight_count;
    syn_b = !syn_sent;
    room  = (avail > {16'd0, syn_b}) ? avail - {16'd0, syn_b} : 17'd0;
    pay   = 11'(MaxPayload);
    if (room < 17'(pay)) pay = room[10:0];
    if ({5'd0, remaining} < 21'(pay)) pay = remaining[10:0];
    fin_b = !fin_sent && cur.stream_done && (remaining == 16'(pay))
            && (avail > 17'(syn_b) + 17'(pay));
    seg_len = 13'(syn_b) + 13'(pay) + 13'(fin_b);
    push_stop = (run_n == RunW'(RunLimit)) || (win < flight_count);
    push_err  = error_flag;
  end

  // held descriptor marked as the last of its run
  always_comb begin
    pend_last = pend;
    pend_last.last_of_run = 1'b1;
  end

  // acknowledgment unwrap
  logic [31:0] ack_d;
  logic [32:0] ack_back;
  logic [63:0] ack_unw;
  always_comb begin
    ack_d    = item.ack_wrapped - initial_seq - next_abs_seq[31:0];
    ack_back = 33'h1_0000_0000 - {1'b0, ack_d};
    if (!ack_d[31]) ack_unw = next_abs_seq + {32'd0, ack_d};
    else if (next_abs_seq >= {31'd0, ack_back}) ack_unw = next_abs_seq - {31'd0, ack_back};
    else ack_unw = next_abs_seq + {32'd0, ack_d};
  end

  // head entry terms
  logic [12:0] head_len;
  logic [32:0] tick_sum;
  assign head_len = 13'(mem_rdata.pay) + 13'(mem_rdata.syn) + 13'(mem_rdata.fin);
  assign tick_sum = {1'b0, timer_elapsed} + {1'b0, cur.elapsed_ms};

  assign busy = (state != S_IDLE);

  // memory port
  always_comb begin
    mem_req.we    = (state == S_PUSH) && !push_stop && !push_err
                    && (queue_count != QCountW'(QueueDepth)) && (seg_len != 13'd0);
    mem_req.waddr = QAddrW'(queue_head + QAddrW'(queue_count));
    mem_req.wdata.start_abs = next_abs_seq;
    mem_req.wdata.pay = pay;
    mem_req.wdata.syn = syn_b;
    mem_req.wdata.fin = fin_b;
    mem_req.raddr = queue_head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      next_abs_seq <= '0; flight_count <= '0; retries <= '0;
      window_held <= 16'd1; syn_sent <= 1'b0; fin_sent <= 1'b0;
      error_flag <= 1'b0; timer_on <= 1'b0; timer_elapsed <= '0;
      current_rto <= 32'd1000; queue_head <= '0; queue_count <= '0;
      result_valid <= 1'b0; run_n <= '0; retired <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur <= item; remaining <= item.bytes_ready; run_n <= '0;
            retired <= 1'b0; ack_abs <= ack_unw;
            unique case (item.opcode)
              OP_PUSH: state <= S_PUSH;
              OP_RECV: begin
                window_held <= item.peer_window;
                if (item.peer_reset) begin
                  error_flag <= 1'b1; timer_on <= 1'b0;
                end
                if (item.peer_reset || error_flag || !item.ack_present
                    || ack_unw > next_abs_seq) begin
                  state <= S_IDLE;
                  result_valid <= 1'b1;
                  result <= '{1'b0, 32'(next_abs_seq) + initial_seq, 10'd0,
                    1'b0, 1'b0, 1'b0, 1'b0, 1'b1, flight_count, retries};
                end else begin
                  state <= S_RECV_RD;
                end
              end
              OP_TICK: state <= S_TICK;
              default: begin
                result_valid <= 1'b1;
                result <= '{1'b0, 32'(next_abs_seq) + initial_seq, 10'd0,
                  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, flight_count, retries};
              end
            endcase
          end
        end
        S_PUSH: begin
          if (push_stop || (!push_err && (queue_count == QCountW'(QueueDepth)
              || seg_len == 13'd0))) begin
            if (queue_count == '0) timer_on <= 1'b0;
            result_valid <= 1'b1;
            if (run_n == '0) begin
              result <= '{1'b0, 32'(next_abs_seq) + initial_seq, 10'd0,
                1'b0, 1'b0, 1'b0, 1'b0, 1'b1, flight_count, retries};
            end else begin
              // held descriptor closes the run
              result <= pend_last;
            end
            state <= S_IDLE;
          end else if (push_err) begin
            result_valid <= 1'b1;
            result <= '{1'b1, 32'(next_abs_seq) + initial_seq, 10'd0,
              1'b0, 1'b0, 1'b1, 1'b0, 1'b1, flight_count, retries};
            if (queue_count == '0) timer_on <= 1'b0;
            state <= S_IDLE;
          end else begin
            syn_sent <= 1'b1;
            if (fin_b) fin_sent <= 1'b1;
            remaining <= remaining - 16'(pay);
            queue_count <= queue_count + 1'b1;
            flight_count <= flight_count + 17'(seg_len);
            next_abs_seq <= next_abs_seq + 64'(seg_len);
            run_n <= run_n + 1'b1;
            if (!timer_on) begin
              timer_on <= 1'b1; timer_elapsed <= '0;
            end
            // each descriptor is held in pend until the end of the run is known
            if (run_n != '0) begin
              result_valid <= 1'b1;
              result <= pend;
            end
            pend <= '{1'b1, 32'(next_abs_seq) + initial_seq, pay[9:0],
              syn_b, fin_b, 1'b0, 1'b0, 1'b0,
              flight_count + 17'(seg_len), retries};
          end
        end
        S_RECV_RD: begin
          // read of head issued, data next cycle
          if (queue_count == '0) begin
            if (retired) begin
              current_rto <= initial_rto_ms; retries <= '0;
            end
            timer_on <= 1'b0;
            timer_elapsed <= retired ? 32'd0 : timer_elapsed;
            result_valid <= 1'b1;
            result <= '{1'b0, 32'(next_abs_seq) + initial_seq, 10'd0,
              1'b0, 1'b0, 1'b0, 1'b0, 1'b1, flight_count,
              retired ? 8'd0 : retries};
            state <= S_IDLE;
          end else begin
            state <= S_RECV_CHK;
          end
        end
        S_RECV_CHK: begin
          if (mem_rdata.start_abs + 64'(head_len) > ack_abs) begin
            if (retired) begin
              current_rto <= initial_rto_ms; retries <= '0;
              timer_on <= 1'b1; timer_elapsed <= '0;
            end
            result_valid <= 1'b1;
            result <= '{1'b0, 32'(next_abs_seq) + initial_seq, 10'd0,
              1'b0, 1'b0, 1'b0, 1'b0, 1'b1, flight_count,
              retired ? 8'd0 : retries};
            state <= S_IDLE;
          end else begin
            flight_count <= (flight_count >= 17'(head_len))
                            ? flight_count - 17'(head_len) : 17'd0;
            queue_head <= queue_head + 1'b1;
            queue_count <= queue_count - 1'b1;
            retired <= 1'b1;
            state <= S_RECV_RD;
          end
        end
        S_TICK: begin
          logic [31:0] te;
          te = timer_on ? (tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0])
                        : timer_elapsed;
          timer_elapsed <= te;
          if (!timer_on || te < current_rto || queue_count == '0) begin
            if (timer_on && te >= current_rto) timer_on <= 1'b0;
            result_valid <= 1'b1;
            result <= '{1'b0, 32'(next_abs_seq) + initial_seq, 10'd0,
              1'b0, 1'b0, 1'b0, 1'b0, 1'b1, flight_count, retries};
            state <= S_IDLE;
          end else begin
            state <= S_TICK_RD;
          end
        end
        S_TICK_RD: state <= S_TICK_OUT;
        S_TICK_OUT: begin
          logic [7:0] r_new;
          r_new = retries;
          if (window_held != 16'd0) begin
            if (retries != 8'hFF) r_new = retries + 8'd1;
            current_rto <= current_rto[31] ? 32'hFFFF_FFFF : {current_rto[30:0], 1'b0};
          end
          retries <= r_new;
          timer_on <= 1'b1; timer_elapsed <= '0;
          result_valid <= 1'b1;
          result <= '{1'b1, mem_rdata.start_abs[31:0] + initial_seq,
            mem_rdata.pay[9:0], mem_rdata.syn, mem_rdata.fin, 1'b0, 1'b1,
            1'b1, flight_count, r_new};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    queue_count <= QCountW'(QueueDepth)) else $error("queue overfilled");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_req.we) else $error("write while idle");
  a_timer_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && queue_count == '0) |-> !timer_on)
    else $error("timer runs with empty queue");
`endif

endmodule
